/* hdl/rgb_to_hue_saturation_macros.svh */
// Assertion macros for the RGB to hue/saturation converter.
`ifndef RGB_TO_HUE_SATURATION_MACROS_SVH
`define RGB_TO_HUE_SATURATION_MACROS_SVH

`ifndef SYNTHESIS

// Check that a condition implies another in the same cycle.
`define RTHS_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("rths: same-cycle check failed");

// Check that a condition implies another in the next cycle.
`define RTHS_ASSERT_NXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("rths: next-cycle check failed");

`else

`define RTHS_ASSERT_IMP(name, pre, post)
`define RTHS_ASSERT_NXT(name, pre, post)

`endif

`endif

/* hdl/rths_pkg.sv */
// Types, widths and helpers shared by the RGB to hue/saturation converter.
package rths_pkg;

  localparam int PIX_W   = 8;
  localparam int HUE_W   = 9;
  localparam int SAT_W   = 8;

  // Hue divider: numerator 2*num + delta, divisor 2*delta.
  localparam int HUE_NW  = 18;
  localparam int HUE_DW  = 9;
  localparam int HUE_QW  = 9;
  // Saturation divider: numerator delta*255, divisor max.
  localparam int SAT_NW  = 16;
  localparam int SAT_DW  = 8;
  localparam int SAT_QW  = 8;

  localparam int DIV_STAGES = HUE_QW;
  localparam int NUM_W      = 19;

  localparam logic [HUE_W-1:0] HUE_MAX = HUE_W'(360);

  // Sector base angle, chosen by the largest channel.
  typedef enum logic [1:0] {
    BASE_0,
    BASE_120,
    BASE_240,
    BASE_360
  } base_e;

  // Word carried through the divider stages.
  typedef struct packed {
    logic [HUE_NW-1:0] hrem;
    logic [HUE_DW-1:0] hden;
    logic [HUE_QW-1:0] hq;
    logic [SAT_NW-1:0] srem;
    logic [SAT_DW-1:0] sden;
    logic [SAT_QW-1:0] sq;
  } div_t;

  function automatic logic [HUE_W-1:0] base_deg(base_e b);
    logic [HUE_W-1:0] deg;
    unique case (b)
      BASE_0:   deg = HUE_W'(0);
      BASE_120: deg = HUE_W'(120);
      BASE_240: deg = HUE_W'(240);
      BASE_360: deg = HUE_W'(360);
      default:  deg = HUE_W'(0);
    endcase
    return deg;
  endfunction

endpackage

/* hdl/rths_pixel_if.sv */
// Handshake channel carrying one RGB pixel.
interface rths_pixel_if import rths_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red;
  logic [PIX_W-1:0] green;
  logic [PIX_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

/* hdl/rths_hs_if.sv */
// Handshake channel carrying one hue/saturation result.
interface rths_hs_if import rths_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [HUE_W-1:0] hue;
  logic [SAT_W-1:0] saturation;

  modport source (output valid, output hue, output saturation, input ready);
  modport sink   (input valid, input hue, input saturation, output ready);
endinterface

/* hdl/rths_div.sv */
// Pipelined restoring divider: hue quotient bit per stage, saturation past the first.
module rths_div import rths_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  div_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output div_t out_data_o
);

  logic [DIV_STAGES-1:0] v_q;
  div_t                  data_q [DIV_STAGES];
  logic [DIV_STAGES:0]   rdy;

  // Chain ready back from the output so bubbles close up
  assign rdy[DIV_STAGES] = out_ready_i;

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    localparam int B = HUE_QW - 1 - i;

    div_t              src;
    logic              src_v;
    div_t              nxt;
    logic [HUE_NW-1:0] hsub;
    logic [SAT_NW-1:0] srem_d;
    logic [SAT_QW-1:0] sq_d;

    if (i == 0) begin : g_first
      assign src   = in_data_i;
      assign src_v = in_valid_i;
    end else begin : g_next
      assign src   = data_q[i-1];
      assign src_v = v_q[i-1];
    end

    assign rdy[i] = !v_q[i] || rdy[i+1];

    // Saturation bit, only for the bits its quotient has
    if (B < SAT_QW) begin : g_sat
      logic [SAT_NW-1:0] ssub;
      assign ssub = SAT_NW'(src.sden) << B;
      always_comb begin
        srem_d = src.srem;
        sq_d   = src.sq;
        if (src.srem >= ssub) begin
          srem_d  = src.srem - ssub;
          sq_d[B] = 1'b1;
        end
      end
    end else begin : g_sat_pass
      assign srem_d = src.srem;
      assign sq_d   = src.sq;
    end

    // Hue bit: subtract the shifted divisor when it fits
    assign hsub = HUE_NW'(src.hden) << B;
    always_comb begin
      nxt      = src;
      nxt.srem = srem_d;
      nxt.sq   = sq_d;
      if (src.hrem >= hsub) begin
        nxt.hrem  = src.hrem - hsub;
        nxt.hq[B] = 1'b1;
      end
    end

    // Advance the valid bit
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (rdy[i]) begin
        v_q[i] <= src_v;
      end
    end

    // Load the word only when one moves in
    always_ff @(posedge clk_i) begin
      if (rdy[i] && src_v) begin
        data_q[i] <= nxt;
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[DIV_STAGES-1];
  assign out_data_o  = data_q[DIV_STAGES-1];

endmodule

/* hdl/rgb_to_hue_saturation.sv */
// Top level of the RGB to hue/saturation converter.
//
// Takes one 8-bit RGB pixel per clock and returns its hue in whole degrees
// (0..360, rounded half up, 360 not wrapped) and saturation floor(delta*255/max).
// A grey pixel gives hue 0; black gives hue 0 and saturation 0. The pipeline
// accepts a pixel every cycle unless back-pressure from a stalled output fills
// it. One stage finds max, min and the hue sector, one forms the hue numerator
// and both divisors, and nine divider stages each retire one quotient bit of
// the hue division (the saturation quotient is done alongside). Ready propagates
// back through every stage, so empty slots fill while the output is stalled.

`include "rgb_to_hue_saturation_macros.svh"

module rgb_to_hue_saturation import rths_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  rths_pixel_if.sink  pix_i,
  rths_hs_if.source   hs_o
);

  // Stage 1 registers
  logic                    s1_v_q;
  logic signed [PIX_W:0]   s1_diff_q;
  logic [PIX_W-1:0]        s1_delta_q;
  logic [PIX_W-1:0]        s1_max_q;
  base_e                   s1_base_q;

  // Stage 2 registers
  logic                    s2_v_q;
  div_t                    s2_q;

  logic                    s1_ready;
  logic                    s2_ready;
  logic                    div_in_ready;

  // Stage 1 next values
  logic [PIX_W-1:0]        max_d;
  logic [PIX_W-1:0]        min_d;
  logic signed [PIX_W:0]   diff_d;
  base_e                   base_d;

  // Stage 2 next values
  logic [HUE_NW-2:0]       base_term;
  logic signed [NUM_W-1:0] diff_x;
  logic signed [NUM_W-1:0] num_s;
  div_t                    s2_d;

  logic                    div_v;
  div_t                    div_q;

  assign s2_ready   = !s2_v_q || div_in_ready;
  assign s1_ready   = !s1_v_q || s2_ready;
  assign pix_i.ready = s1_ready;

  // Pick max, min, sector and channel difference; red wins ties, then green
  always_comb begin
    max_d = pix_i.red;
    min_d = pix_i.red;
    if (pix_i.green > max_d) max_d = pix_i.green;
    if (pix_i.blue  > max_d) max_d = pix_i.blue;
    if (pix_i.green < min_d) min_d = pix_i.green;
    if (pix_i.blue  < min_d) min_d = pix_i.blue;

    priority if (pix_i.red >= pix_i.green && pix_i.red >= pix_i.blue) begin
      diff_d = $signed({1'b0, pix_i.green}) - $signed({1'b0, pix_i.blue});
      base_d = (pix_i.green < pix_i.blue) ? BASE_360 : BASE_0;
    end else if (pix_i.green >= pix_i.blue) begin
      diff_d = $signed({1'b0, pix_i.blue}) - $signed({1'b0, pix_i.red});
      base_d = BASE_120;
    end else begin
      diff_d = $signed({1'b0, pix_i.red}) - $signed({1'b0, pix_i.green});
      base_d = BASE_240;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_ready) begin
      s1_v_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && pix_i.valid) begin
      s1_diff_q  <= diff_d;
      s1_delta_q <= max_d - min_d;
      s1_max_q   <= max_d;
      s1_base_q  <= base_d;
    end
  end

  // Form hue numerator 2*(base*delta + 60*diff) + delta and both divisors
  assign base_term = (HUE_NW-1)'(base_deg(s1_base_q)) * (HUE_NW-1)'(s1_delta_q);
  assign diff_x    = NUM_W'(s1_diff_q);
  assign num_s     = diff_x * NUM_W'(60) + $signed(NUM_W'(base_term));

  always_comb begin
    s2_d      = '0;
    s2_d.hrem = {num_s[HUE_NW-2:0], 1'b0} + HUE_NW'(s1_delta_q);
    s2_d.hden = (s1_delta_q == '0) ? HUE_DW'(2) : {s1_delta_q, 1'b0};
    s2_d.srem = {s1_delta_q, {PIX_W{1'b0}}} - SAT_NW'(s1_delta_q);
    s2_d.sden = (s1_max_q == '0) ? SAT_DW'(1) : s1_max_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_ready) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_v_q) begin
      s2_q <= s2_d;
    end
  end

  // Divide in nine bit-stages
  rths_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s2_v_q),
    .in_ready_o  (div_in_ready),
    .in_data_i   (s2_q),
    .out_valid_o (div_v),
    .out_ready_i (hs_o.ready),
    .out_data_o  (div_q)
  );

  assign hs_o.valid      = div_v;
  assign hs_o.hue        = div_q.hq;
  assign hs_o.saturation = div_q.sq;

  `RTHS_ASSERT_IMP(a_hue_range, hs_o.valid, hs_o.hue <= HUE_MAX)
  `RTHS_ASSERT_IMP(a_idle_ready, !hs_o.valid, pix_i.ready)
  `RTHS_ASSERT_IMP(a_den_nonzero, s2_v_q, (s2_q.hden != '0) && (s2_q.sden != '0))
  `RTHS_ASSERT_NXT(a_accept_fills, pix_i.valid && pix_i.ready, s1_v_q)

endmodule
